/* rtl/nmf_pkg.sv */
// Shared word types, constants and the exponent table for the nozzle mass flow unit.
package nmf_pkg;

  localparam logic [23:0] OUTLET_RESET = 24'd101325;
  localparam logic [16:0] GAMMA_MIN    = 17'd65537;
  localparam logic [29:0] AREA_SCALE   = 30'd1000000000;

  typedef struct packed {
    logic [23:0] upstream_pressure;
    logic [17:0] upstream_temperature;
    logic [17:0] gas_constant;
    logic [17:0] heat_capacity;
    logic [16:0] heat_ratio;
    logic [31:0] nozzle_area;
  } in_t;

  typedef struct packed {
    logic [39:0] mass_flow;
    logic        choked;
    logic        reverse_zeroed;
    logic        saturated;
  } out_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] r;
    logic [63:0] bv;
    xr = x;
    r  = '0;
    bv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (xr >= r + bv) begin
        xr = xr - (r + bv);
        r  = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-(k+1)) in Q1.31, built by repeated square roots from one half
  function automatic logic [31:0] pow_tab(input int k);
    logic [63:0] v;
    logic [63:0] r;
    v = 64'd1 << 61;
    r = '0;
    for (int j = 0; j <= k; j++) begin
      r = isqrt64(v);
      v = r << 31;
    end
    return r[31:0];
  endfunction

endpackage

/* rtl/nozzle_mass_flow_unit.sv */
// Top level of the nozzle mass flow unit: outlet pressure register and word handshake.
//
// Computes isentropic mass flow through a nozzle for one cell per input word, with
// the choked-flow limit, reverse-flow zeroing and output saturation flagged. The
// datapath is a 299-stage pipeline: three 32-step squaring logarithms, restoring
// dividers of 34, 37, 61 and 60 steps, two 32-step table exponentials and a 31-step
// square root, each step one register stage. A word is taken every cycle unless the
// pipeline holds; throughput is one word per clock while it advances. When the
// result at the output is stalled, the whole pipeline holds, and the input is
// stalled in the same cycle. The outlet pressure is sampled as each word enters;
// write it only while the unit is empty. Reset sets it to 101325 Pa.
module nozzle_mass_flow_unit
  import nmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_word
);

  logic [23:0] outlet_pressure;
  logic        adv;
  logic        done_valid;

  // hold the downstream pressure until software rewrites it
  always_ff @(posedge clk) begin
    if (rst) begin
      outlet_pressure <= OUTLET_RESET;
    end else if (cfg_wr_en) begin
      outlet_pressure <= cfg_wr_data;
    end
  end

  // advance unless a finished word is waiting on a stalled output
  assign adv       = !(done_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = done_valid;

  nmf_pipe u_pipe (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .load_valid      (in_valid),
    .load_word       (in_word),
    .outlet_pressure (outlet_pressure),
    .done_valid      (done_valid),
    .done_word       (out_word)
  );

endmodule

/* rtl/nmf_pipe.sv */
// Datapath pipeline of the nozzle mass flow unit: logs, dividers, exponents, root, product.
module nmf_pipe
  import nmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        load_valid,
  input  in_t         load_word,
  input  logic [23:0] outlet_pressure,
  output logic        done_valid,
  output out_t        done_word
);

  localparam int LOG0 = 1;
  localparam int LR   = LOG0 + 32;
  localparam int DC0  = LR + 1;
  localparam int SEL  = DC0 + 34;
  localparam int DE0  = SEL + 1;
  localparam int SPL  = DE0 + 37;
  localparam int EX0  = SPL + 1;
  localparam int SHF  = EX0 + 32;
  localparam int PR1  = SHF + 1;
  localparam int PR2  = PR1 + 1;
  localparam int DT0  = PR2 + 1;
  localparam int SQI  = DT0 + 61;
  localparam int SQ0  = SQI + 1;
  localparam int PR3  = SQ0 + 31;
  localparam int PR4  = PR3 + 1;
  localparam int DSET = PR4 + 1;
  localparam int DF0  = DSET + 1;
  localparam int FIN  = DF0 + 60;
  localparam int NST  = FIN + 1;

  typedef struct packed {
    logic         rev;
    logic [23:0]  p1;
    logic [23:0]  p2;
    logic [17:0]  t1;
    logic [17:0]  cp;
    logic [16:0]  g;
    logic [55:0]  pa;
    logic [47:0]  drg;
    logic [4:0]   pp1;
    logic [4:0]   pp2;
    logic [31:0]  mg;
    logic [31:0]  m1;
    logic [31:0]  m2;
    logic [31:0]  yg;
    logic [31:0]  y1;
    logic [31:0]  y2;
    logic [36:0]  lr;
    logic [36:0]  l;
    logic         choked;
    logic [47:0]  dr;
    logic [47:0]  dd;
    logic [63:0]  dq;
    logic [36:0]  ea;
    logic [36:0]  eb;
    logic [31:0]  ma;
    logic [31:0]  mb;
    logic [31:0]  omb;
    logic         zero;
    logic         inf;
    logic [48:0]  cpo;
    logic [63:0]  pal;
    logic [55:0]  pah;
    logic [87:0]  pb;
    logic [61:0]  sx;
    logic [61:0]  sr;
    logic [62:0]  q0;
    logic [62:0]  q1;
    logic [54:0]  q2;
    logic [118:0] pc;
    logic         ovf;
    logic [39:0]  flow;
    logic         sat;
  } pl_t;

  pl_t            pipe [NST];
  pl_t            nx   [NST];
  logic [NST-1:0] vld;

  function automatic logic [4:0] msb24(input logic [23:0] v);
    logic [4:0] p;
    p = '0;
    for (int j = 0; j < 24; j++) begin
      if (v[j]) p = 5'(j);
    end
    return p;
  endfunction

  // one squaring step of the log: returns {mantissa, log bits}
  function automatic logic [63:0] log_step(input logic [31:0] m, input logic [31:0] y);
    logic [63:0] sq;
    logic [32:0] t;
    logic [31:0] mo;
    sq = 64'(m) * 64'(m);
    t  = sq[63:31];
    mo = t[32] ? t[32:1] : t[31:0];
    return {mo, y[30:0], t[32]};
  endfunction

  // one restoring divider step: shift a numerator bit in, subtract when it fits
  function automatic pl_t div_step(input pl_t x);
    pl_t         y;
    logic [48:0] t;
    logic [48:0] diff;
    logic        ge;
    y    = x;
    t    = {x.dr, x.dq[63]};
    diff = t - {1'b0, x.dd};
    ge   = (t >= {1'b0, x.dd});
    y.dr = ge ? diff[47:0] : t[47:0];
    y.dq = {x.dq[62:0], ge};
    return y;
  endfunction

  for (genvar i = 0; i < NST; i++) begin : g_stage
    pl_t cur;
    if (i == 0) begin : g_in
      always_comb begin
        cur     = '0;
        cur.p1  = load_word.upstream_pressure;
        cur.p2  = outlet_pressure;
        cur.t1  = load_word.upstream_temperature;
        cur.cp  = load_word.heat_capacity;
        cur.g   = (load_word.heat_ratio < GAMMA_MIN) ? GAMMA_MIN : load_word.heat_ratio;
        cur.rev = load_word.upstream_pressure < outlet_pressure;
        cur.pa  = 56'(load_word.nozzle_area) * 56'(load_word.upstream_pressure);
        cur.drg = 48'(load_word.gas_constant) * 48'(AREA_SCALE);
        cur.pp1 = msb24(load_word.upstream_pressure);
        cur.pp2 = msb24(outlet_pressure);
        cur.m1  = 32'(load_word.upstream_pressure) << (5'd31 - cur.pp1);
        cur.m2  = 32'(outlet_pressure) << (5'd31 - cur.pp2);
        cur.mg  = {18'(cur.g) + 18'd65536, 14'b0};
      end
    end else if (i < LR) begin : g_log
      always_comb begin
        cur = pipe[i-1];
        {cur.mg, cur.yg} = log_step(pipe[i-1].mg, pipe[i-1].yg);
        {cur.m1, cur.y1} = log_step(pipe[i-1].m1, pipe[i-1].y1);
        {cur.m2, cur.y2} = log_step(pipe[i-1].m2, pipe[i-1].y2);
      end
    end else if (i == LR) begin : g_lr
      logic [36:0] lp1;
      logic [36:0] lp2;
      logic [48:0] num;
      always_comb begin
        cur    = pipe[i-1];
        lp1    = {pipe[i-1].pp1, pipe[i-1].y1};
        lp2    = {pipe[i-1].pp2, pipe[i-1].y2};
        cur.lr = (lp1 >= lp2) ? lp1 - lp2 : '0;
        num    = 49'(pipe[i-1].yg) * 49'(pipe[i-1].g);
        cur.dr = 48'(num[48:34]);
        cur.dq = {num[33:0], 30'b0};
        cur.dd = 48'(pipe[i-1].g) - 48'd65536;
      end
    end else if (i < SEL) begin : g_divc
      always_comb cur = div_step(pipe[i-1]);
    end else if (i == SEL) begin : g_sel
      logic [36:0] lc;
      always_comb begin
        cur        = pipe[i-1];
        lc         = 37'(pipe[i-1].dq[33:0]);
        cur.choked = (pipe[i-1].p2 == '0) || (pipe[i-1].lr >= lc);
        cur.l      = cur.choked ? lc : pipe[i-1].lr;
        cur.dr     = 48'(cur.l[36:21]);
        cur.dq     = {cur.l[20:0], 43'b0};
        cur.dd     = 48'(pipe[i-1].g);
      end
    end else if (i < SPL) begin : g_dive
      always_comb cur = div_step(pipe[i-1]);
    end else if (i == SPL) begin : g_spl
      always_comb begin
        cur    = pipe[i-1];
        cur.ea = pipe[i-1].dq[36:0];
        cur.eb = pipe[i-1].l - pipe[i-1].dq[36:0];
        cur.ma = 32'h8000_0000;
        cur.mb = 32'h8000_0000;
      end
    end else if (i < SHF) begin : g_exp
      localparam logic [31:0] TABK = pow_tab(i - EX0);
      logic [63:0] pa_m;
      logic [63:0] pb_m;
      always_comb begin
        cur  = pipe[i-1];
        pa_m = 64'(pipe[i-1].ma) * 64'(TABK);
        pb_m = 64'(pipe[i-1].mb) * 64'(TABK);
        if (pipe[i-1].ea[31 - (i - EX0)]) cur.ma = pa_m[62:31];
        if (pipe[i-1].eb[31 - (i - EX0)]) cur.mb = pb_m[62:31];
      end
    end else if (i == SHF) begin : g_shf
      logic [31:0] b;
      always_comb begin
        cur     = pipe[i-1];
        cur.ma  = pipe[i-1].ma >> pipe[i-1].ea[36:32];
        b       = pipe[i-1].mb >> pipe[i-1].eb[36:32];
        cur.mb  = b;
        cur.omb = 32'h8000_0000 - b;
      end
    end else if (i == PR1) begin : g_pr1
      logic [49:0] cpw;
      always_comb begin
        cur      = pipe[i-1];
        cur.zero = (pipe[i-1].pa == '0) || (pipe[i-1].ma == '0) ||
                   (pipe[i-1].cp == '0) || (pipe[i-1].omb == '0);
        cur.inf  = (pipe[i-1].t1 == '0) || (pipe[i-1].drg == '0);
        cpw      = 50'(pipe[i-1].cp) * 50'(pipe[i-1].omb);
        cur.cpo  = cpw[48:0];
        cur.pal  = 64'(pipe[i-1].pa[31:0]) * 64'(pipe[i-1].ma);
        cur.pah  = 56'(pipe[i-1].pa[55:32]) * 56'(pipe[i-1].ma);
      end
    end else if (i == PR2) begin : g_pr2
      always_comb begin
        cur    = pipe[i-1];
        cur.pb = 88'(pipe[i-1].pal) + {pipe[i-1].pah, 32'b0};
        cur.dr = '0;
        cur.dq = {pipe[i-1].cpo, 15'b0};
        cur.dd = 48'(pipe[i-1].t1);
      end
    end else if (i < SQI) begin : g_divt
      always_comb cur = div_step(pipe[i-1]);
    end else if (i == SQI) begin : g_sqi
      always_comb begin
        cur    = pipe[i-1];
        cur.sx = 62'(pipe[i-1].dq[60:0]);
        cur.sr = '0;
      end
    end else if (i < PR3) begin : g_sqrt
      localparam logic [61:0] BV = 62'd1 << (2 * (30 - (i - SQ0)));
      logic [61:0] trial;
      always_comb begin
        cur   = pipe[i-1];
        trial = pipe[i-1].sr + BV;
        if (pipe[i-1].sx >= trial) begin
          cur.sx = pipe[i-1].sx - trial;
          cur.sr = (pipe[i-1].sr >> 1) + BV;
        end else begin
          cur.sr = pipe[i-1].sr >> 1;
        end
      end
    end else if (i == PR3) begin : g_pr3
      always_comb begin
        cur    = pipe[i-1];
        cur.q0 = 63'(pipe[i-1].pb[31:0]) * 63'(pipe[i-1].sr[30:0]);
        cur.q1 = 63'(pipe[i-1].pb[63:32]) * 63'(pipe[i-1].sr[30:0]);
        cur.q2 = 55'(pipe[i-1].pb[87:64]) * 55'(pipe[i-1].sr[30:0]);
      end
    end else if (i == PR4) begin : g_pr4
      always_comb begin
        cur    = pipe[i-1];
        cur.pc = 119'(pipe[i-1].q0) + 119'({pipe[i-1].q1, 32'b0}) +
                 {pipe[i-1].q2, 64'b0};
      end
    end else if (i == DSET) begin : g_dset
      logic [58:0] hi;
      always_comb begin
        cur     = pipe[i-1];
        hi      = pipe[i-1].pc[118:60];
        cur.ovf = hi >= 59'(pipe[i-1].drg);
        cur.dr  = cur.ovf ? '0 : hi[47:0];
        cur.dq  = {pipe[i-1].pc[59:0], 4'b0};
        cur.dd  = pipe[i-1].drg;
      end
    end else if (i < FIN) begin : g_divf
      always_comb cur = div_step(pipe[i-1]);
    end else begin : g_fin
      always_comb begin
        cur = pipe[i-1];
        if (pipe[i-1].rev) begin
          cur.flow   = '0;
          cur.choked = 1'b0;
          cur.sat    = 1'b0;
        end else if (pipe[i-1].zero) begin
          cur.flow = '0;
          cur.sat  = 1'b0;
        end else if (pipe[i-1].inf || pipe[i-1].ovf) begin
          cur.flow = '1;
          cur.sat  = 1'b1;
        end else begin
          cur.flow = pipe[i-1].dq[59:20];
          cur.sat  = 1'b0;
        end
      end
    end
    assign nx[i] = cur;
  end

  // advance every stage together; hold everything while the result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], load_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe <= nx;
    end
  end

  assign done_valid               = vld[NST-1];
  assign done_word.mass_flow      = pipe[NST-1].flow;
  assign done_word.choked         = pipe[NST-1].choked;
  assign done_word.reverse_zeroed = pipe[NST-1].rev;
  assign done_word.saturated      = pipe[NST-1].sat;

endmodule
